/* rtl/lje_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the lossless JPEG scan encoder.
// No dependencies; the front, queue, back, top and testbench files import this package.
package lje_pkg;

  localparam int NUM_CATEGORIES = 17;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

  // request codes
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_SAMPLE = 2'd1;
  localparam logic [1:0] REQ_FLUSH  = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  localparam logic [15:0] FIRST_PRED  = 16'h8000;
  localparam logic [15:0] WIDTH_RESET = 16'd1;
  localparam logic [4:0]  MAX_LEN     = 5'd16;
  localparam logic [4:0]  CAT_FULL    = 5'd16;
  localparam logic [7:0]  BYTE_FF     = 8'hFF;
  localparam logic [7:0]  STUFF_BYTE  = 8'h00;
  localparam logic [2:0]  MAX_BYTES   = 3'd4;

  // one group of code bits handed from front to back, MSB first, left aligned
  typedef struct packed {
    logic        flush;
    logic [5:0]  nbits;
    logic [31:0] bits;
  } grp_t;

endpackage

/* rtl/lje_ifs.sv */
`timescale 1ns / 1ps
// Channel interfaces of the scan encoder: requests, output bytes, width register.
// No dependencies.
interface lje_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] sample;
  logic [4:0]  table_symbol;
  logic [15:0] table_code;
  logic [4:0]  table_length;

  modport source(output valid, req_type, sample, table_symbol, table_code, table_length,
                 input ready);
  modport sink(input valid, req_type, sample, table_symbol, table_code, table_length,
               output ready);
endinterface

interface lje_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source(output valid, out_byte, last_of_run, input ready);
  modport sink(input valid, out_byte, last_of_run, output ready);
endinterface

interface lje_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] image_width;

  modport source(output valid, image_width, input ready);
  modport sink(input valid, image_width, output ready);
endinterface

/* rtl/lje_front.sv */
`timescale 1ns / 1ps
// Front end: accepts requests, predicts, classifies and looks up code tables,
// then pushes left-aligned bit groups into the queue. Uses lje_pkg and lje_ifs.
module lje_front
  import lje_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  lje_req_if.sink       req,
  lje_cfg_if.sink       cfg,
  input  logic          q_full,
  output logic          q_push,
  output grp_t          q_data
);

  logic [15:0] image_width;
  logic [15:0] left_sample;
  logic [15:0] row_first_sample;
  logic [15:0] column_position;
  logic        past_first_row;

  logic [15:0] code_table [NUM_CATEGORIES];
  logic [4:0]  length_table [NUM_CATEGORIES];

  // stage one registers
  logic        s1_valid;
  logic [1:0]  s1_type;
  logic [4:0]  s1_cat;
  logic [4:0]  s1_mlen;
  logic [15:0] s1_mag;
  logic [4:0]  s1_sym;
  logic [15:0] s1_code;
  logic [4:0]  s1_len;

  logic        s1_take;
  logic        accept;
  logic [15:0] pred;
  logic [15:0] diff;
  logic [15:0] absd;
  logic [15:0] mbits;
  logic [4:0]  cat;
  logic [4:0]  mlen;
  logic [15:0] mag_al;
  logic [15:0] col_inc;
  logic [4:0]  code_len;
  logic [15:0] code_al;
  logic [31:0] grp_bits;

  assign cfg.ready = 1'b1;

  // stage one drains when a load leaves or the queue has room
  assign s1_take   = s1_valid && ((s1_type == REQ_LOAD) || !q_full);
  assign req.ready = !s1_valid || s1_take;
  assign accept    = req.valid && req.ready;
  assign col_inc   = column_position + 16'd1;

  // predict and classify the incoming sample
  always_comb begin
    if (column_position == 16'd0) begin
      pred = past_first_row ? row_first_sample : FIRST_PRED;
    end else begin
      pred = left_sample;
    end
    diff  = req.sample - pred;
    absd  = diff[15] ? (~diff + 16'd1) : diff;
    mbits = diff[15] ? (diff - 16'd1) : diff;
    cat   = 5'd0;
    for (int i = 0; i < 15; i++) begin
      if (absd[i]) cat = 5'(i + 1);
    end
    if (diff == FIRST_PRED) cat = CAT_FULL;
    mlen   = (cat != 5'd0 && cat != CAT_FULL) ? cat : 5'd0;
    mag_al = (mlen != 5'd0) ? (mbits << (MAX_LEN - mlen)) : 16'd0;
  end

  // width register
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WIDTH_RESET;
    end else if (cfg.valid) begin
      image_width <= cfg.image_width;
    end
  end

  // position and predictor state, updated in request order
  always_ff @(posedge clk) begin
    if (rst) begin
      left_sample      <= '0;
      row_first_sample <= '0;
      column_position  <= '0;
      past_first_row   <= 1'b0;
    end else if (accept) begin
      if (req.req_type == REQ_SAMPLE) begin
        left_sample <= req.sample;
        if (column_position == 16'd0) row_first_sample <= req.sample;
        if (col_inc >= image_width) begin
          column_position <= '0;
          past_first_row  <= 1'b1;
        end else begin
          column_position <= col_inc;
        end
      end else if (req.req_type == REQ_FLUSH) begin
        column_position <= '0;
        past_first_row  <= 1'b0;
      end
    end
  end

  // stage one capture; unused request codes drop here
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept && req.req_type != REQ_NONE) begin
      s1_valid <= 1'b1;
    end else if (s1_take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_type <= req.req_type;
      s1_cat  <= cat;
      s1_mlen <= mlen;
      s1_mag  <= mag_al;
      s1_sym  <= req.table_symbol;
      s1_code <= req.table_code;
      s1_len  <= req.table_length;
    end
  end

  // table writes happen at stage two so earlier samples see the old entry
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CATEGORIES; i++) begin
        code_table[i]   <= '0;
        length_table[i] <= '0;
      end
    end else if (s1_take && s1_type == REQ_LOAD &&
                 s1_sym < 5'(NUM_CATEGORIES)) begin
      code_table[s1_sym]   <= s1_code;
      length_table[s1_sym] <= (s1_len > MAX_LEN) ? MAX_LEN : s1_len;
    end
  end

  // stage two: join code and magnitude bits, MSB first
  always_comb begin
    code_len = length_table[s1_cat];
    code_al  = code_table[s1_cat] << (MAX_LEN - code_len);
    grp_bits = {code_al, 16'd0} | ({s1_mag, 16'd0} >> code_len);
    q_data.flush = (s1_type == REQ_FLUSH);
    if (s1_type == REQ_FLUSH) begin
      q_data.nbits = 6'd0;
      q_data.bits  = '0;
    end else begin
      q_data.nbits = {1'b0, code_len} + {1'b0, s1_mlen};
      q_data.bits  = grp_bits;
    end
  end

  assign q_push = s1_valid && (s1_type != REQ_LOAD) && !q_full;

endmodule

/* rtl/lje_queue.sv */
`timescale 1ns / 1ps
// Short queue of bit groups between front and back end.
// Uses lje_pkg for grp_t and the depth.
module lje_queue
  import lje_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  grp_t push_data,
  output logic full,
  input  logic pop,
  output grp_t pop_data,
  output logic empty
);

  grp_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign full     = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rptr];

  // write the slot at the tail
  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_data;
  end

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop) else $error("queue pop while empty");

endmodule

/* rtl/lje_back.sv */
`timescale 1ns / 1ps
// Back end: packs bit groups into bytes, stuffs 0x00 after 0xFF, pads on flush,
// and drives the output register. Uses lje_pkg and lje_ifs.
module lje_back
  import lje_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  grp_t       q_data,
  output logic       q_pop,
  lje_byte_if.source res
);

  // top byte of work holds the pending bits while idle
  logic [39:0] work;
  logic [2:0]  nbytes;
  logic        stuff;
  logic [2:0]  pcnt;

  logic [7:0]  obyte;
  logic        olast;
  logic        ovalid;

  logic        idle;
  logic        out_free;
  logic        emit;
  logic [5:0]  total;
  logic [7:0]  head;

  assign idle     = (nbytes == 3'd0) && !stuff;
  assign out_free = !ovalid || res.ready;
  assign emit     = !idle && out_free;
  assign q_pop    = idle && !q_empty;
  assign total    = {3'd0, pcnt} + q_data.nbits;
  assign head     = work[39:32];

  assign res.valid       = ovalid;
  assign res.out_byte    = obyte;
  assign res.last_of_run = olast;

  // load a group or step out one byte
  always_ff @(posedge clk) begin
    if (rst) begin
      work   <= '0;
      nbytes <= '0;
      stuff  <= 1'b0;
      pcnt   <= '0;
    end else if (q_pop) begin
      if (q_data.flush) begin
        pcnt <= '0;
        if (pcnt != 3'd0) begin
          work   <= {head | (BYTE_FF >> pcnt), 32'd0};
          nbytes <= 3'd1;
        end else begin
          work   <= '0;
          nbytes <= 3'd0;
        end
      end else begin
        work   <= {head, 32'd0} | ({q_data.bits, 8'd0} >> pcnt);
        nbytes <= total[5:3];
        pcnt   <= total[2:0];
      end
    end else if (emit) begin
      if (stuff) begin
        stuff <= 1'b0;
      end else begin
        stuff  <= (head == BYTE_FF);
        work   <= {work[31:0], 8'd0};
        nbytes <= nbytes - 3'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (out_free) begin
      ovalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (stuff) begin
        obyte <= STUFF_BYTE;
        olast <= (nbytes == 3'd0);
      end else begin
        obyte <= head;
        olast <= (nbytes == 3'd1) && (head != BYTE_FF);
      end
    end
  end

  a_bytes_bound: assert property (@(posedge clk) disable iff (rst)
    nbytes <= MAX_BYTES) else $error("too many bytes queued in packer");
  a_stuff_follows_ff: assert property (@(posedge clk) disable iff (rst)
    stuff |-> (ovalid && obyte == BYTE_FF)) else $error("stuffing without 0xFF");
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_data.flush) |=> (pcnt == 3'd0)) else $error("flush left bits pending");

endmodule

/* rtl/lossless_jpeg_scan_encoder.sv */
`timescale 1ns / 1ps
// Lossless JPEG scan encoder (predictor 1, Huffman coded), top level.
// Depends on lje_pkg, lje_ifs, lje_front, lje_queue and lje_back.
//
// Channels: req carries table loads, samples and flush requests; res carries
// scan bytes with last_of_run on the final byte of each request; cfg writes
// image_width (always ready) only while the block is idle; the user ensures it, not the block.
// Path: with the queue and packer empty, a sample passes the front stage, the
// queue and the packer load, and then its first byte sits in the output register.
// Flow: the front takes one request per cycle while the queue has room; the
// packer takes a new group only once it has put out every byte of the last one,
// stuffing bytes included.
// Table loads produce no bytes and cost the packer nothing.
// Reset: synchronous, active high; clears tables, position, pending bits,
// and sets image_width to 1. No clearing pass is needed.
// Receiver stall: the output register holds its byte, the packer stops, the
// four-entry queue fills, and then req.ready drops until space returns.
module lossless_jpeg_scan_encoder
  import lje_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  lje_req_if.sink    req,
  lje_byte_if.source res,
  lje_cfg_if.sink    cfg
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  grp_t q_in;
  grp_t q_out;

  lje_front u_front (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  lje_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  lje_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .res     (res)
  );

endmodule

/* tb/lje_scan_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the scan encoder: snoops the request, config and byte channels,
// predicts the scan byte stream and compares it. Depends on lje_pkg and lje_ifs.
module lje_scan_checker
  import lje_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  lje_req_if    req,
  lje_byte_if   res,
  lje_cfg_if    cfg,
  output int    results_due,
  output int    fail_count
);

  localparam logic [15:0] MOST_NEGATIVE = 16'h8000;
  localparam int          REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } scan_byte_t;

  scan_byte_t  scan_bytes_due[$];

  // predictor state
  logic [15:0] code_tab [NUM_CATEGORIES];
  logic [4:0]  len_tab  [NUM_CATEGORIES];
  logic [15:0] left_px;
  logic [15:0] row_head_px;
  logic [15:0] column;
  logic [15:0] width;
  logic        below_first_row;
  logic [6:0]  held_bits;
  logic [2:0]  held_count;
  int          emitted;
  int          mismatches = 0;

  // SSSS category of a 16-bit difference
  function automatic int category_of_diff(input logic [15:0] d);
    logic [15:0] mag;
    int          s;
    if (d == MOST_NEGATIVE) return int'(CAT_FULL);
    mag = d[15] ? 16'(~d + 16'd1) : d;
    s = 0;
    while (mag != 16'd0) begin
      s++;
      mag = mag >> 1;
    end
    return s;
  endfunction

  // Queue one expected byte at the tail
  task automatic expect_byte(input logic [7:0] b);
    scan_byte_t item;
    item.data = b;
    item.last = 1'b0;
    scan_bytes_due = {scan_bytes_due, item};
    emitted++;
  endtask

  // Append n bits MSB first; cut whole bytes and stuff after 0xFF
  task automatic shift_into_bytes(input logic [31:0] bits, input int n);
    logic [63:0] acc;
    logic [7:0]  b;
    int          total;
    if (n == 0) return;
    acc = ({57'd0, held_bits} << n) | ({32'd0, bits} & ((64'd1 << n) - 64'd1));
    total = int'(held_count) + n;
    while (total >= 8) begin
      b = 8'(acc >> (total - 8));
      expect_byte(b);
      if (b == BYTE_FF) expect_byte(STUFF_BYTE);
      total -= 8;
    end
    held_count = 3'(total);
    held_bits  = 7'(acc & ((64'd1 << total) - 64'd1));
  endtask

  // Work out the bytes one request word causes
  task automatic predict_scan_bytes(input logic [1:0] kind, input logic [15:0] px,
                                    input logic [4:0] sym, input logic [15:0] code,
                                    input logic [4:0] len);
    logic [15:0] pred;
    logic [15:0] d;
    logic [15:0] mag_bits;
    int          cat;
    int          pad;
    scan_byte_t  tail;
    emitted = 0;
    case (kind)
      REQ_LOAD: begin
        if (sym < NUM_CATEGORIES) begin
          code_tab[sym] = code;
          len_tab[sym]  = (len > MAX_LEN) ? MAX_LEN : len;
        end
      end
      REQ_SAMPLE: begin
        if (column == 16'd0) begin
          pred = below_first_row ? row_head_px : FIRST_PRED;
          row_head_px = px;
        end else begin
          pred = left_px;
        end
        d = px - pred;
        cat = category_of_diff(d);
        shift_into_bytes({16'd0, code_tab[cat]}, int'(len_tab[cat]));
        if (cat >= 1 && cat <= 15) begin
          mag_bits = d[15] ? d - 16'd1 : d;
          shift_into_bytes({16'd0, mag_bits}, cat);
        end
        left_px = px;
        column = column + 16'd1;
        if (column >= width) begin
          column = 16'd0;
          below_first_row = 1'b1;
        end
      end
      REQ_FLUSH: begin
        if (held_count != 3'd0) begin
          pad = 8 - int'(held_count);
          shift_into_bytes((32'd1 << pad) - 32'd1, pad);
        end
        held_bits = '0;
        held_count = '0;
        column = '0;
        below_first_row = 1'b0;
      end
      default: ;
    endcase
    // mark the final byte of this word
    if (emitted > 0) begin
      tail = scan_bytes_due[scan_bytes_due.size() - 1];
      tail.last = 1'b1;
      scan_bytes_due[scan_bytes_due.size() - 1] = tail;
    end
  endtask

  always @(posedge clk) begin
    scan_byte_t want;
    if (rst) begin
      foreach (code_tab[i]) begin
        code_tab[i] = '0;
        len_tab[i] = '0;
      end
      left_px = '0;
      row_head_px = '0;
      column = '0;
      below_first_row = 1'b0;
      held_bits = '0;
      held_count = '0;
      width = WIDTH_RESET;
      scan_bytes_due.delete();
    end else begin
      if (cfg.valid && cfg.ready) width = cfg.image_width;

      // compare each output word with the oldest expected byte
      if (res.valid && res.ready) begin
        if (scan_bytes_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: unexpected scan byte %02h last %0b", $realtime,
                     res.out_byte, res.last_of_run);
        end else begin
          want = scan_bytes_due.pop_front();
          if (want.data !== res.out_byte || want.last !== res.last_of_run) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("%0t: scan byte mismatch: expected %02h last %0b, got %02h last %0b",
                       $realtime, want.data, want.last, res.out_byte, res.last_of_run);
          end
        end
      end

      if (req.valid && req.ready)
        predict_scan_bytes(req.req_type, req.sample, req.table_symbol, req.table_code,
                           req.table_length);
    end
    results_due <= scan_bytes_due.size();
    fail_count  <= mismatches;
  end

endmodule

/* tb/tb_lossless_jpeg_scan_encoder.sv */
`timescale 1ns / 1ps
// Top of the scan encoder testbench: clock, reset, request and width stimulus,
// output back-pressure and the verdict. Depends on lje_pkg, lje_ifs, lossless_jpeg_scan_encoder, lje_scan_checker.
module tb_lossless_jpeg_scan_encoder;
  import lje_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [15:0] WIDTH_PLAN [16] = '{
    16'd1, 16'd0, 16'd65535, 16'd3, 16'd2, 16'd5, 16'd1, 16'd7,
    16'd65535, 16'd4, 16'd0, 16'd2, 16'd6, 16'd3, 16'd1, 16'd8
  };

  logic        clk = 1'b0;
  logic        rst;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int          results_due;
  int          fail_count;
  int          idle_cycles = 0;
  logic [15:0] prev_px = 16'd0;

  lje_req_if  req_ch();
  lje_byte_if byte_ch();
  lje_cfg_if  cfg_ch();

  lossless_jpeg_scan_encoder dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(byte_ch),
    .cfg(cfg_ch)
  );

  lje_scan_checker u_checker (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(byte_ch),
    .cfg(cfg_ch),
    .results_due(results_due),
    .fail_count(fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // random back-pressure on the byte channel
  always @(posedge clk) begin
    byte_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // end the run if no word moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (byte_ch.valid && byte_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Offer one request word after a random gap and hold it until accepted
  task automatic send_req(input logic [1:0] kind, input logic [15:0] px,
                          input logic [4:0] sym, input logic [15:0] code,
                          input logic [4:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.sample <= px;
    req_ch.table_symbol <= sym;
    req_ch.table_code <= code;
    req_ch.table_length <= len;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic send_sample(input logic [15:0] px);
    send_req(REQ_SAMPLE, px, 5'($urandom), 16'($urandom), 5'($urandom));
    prev_px = px;
  endtask

  task automatic send_flush();
    send_req(REQ_FLUSH, 16'($urandom), 5'($urandom), 16'($urandom), 5'($urandom));
  endtask

  task automatic load_entry(input logic [4:0] sym, input logic [15:0] code,
                            input logic [4:0] len);
    send_req(REQ_LOAD, 16'($urandom), sym, code, len);
  endtask

  // Drain the encoder, let in-flight words settle, then write the width
  task automatic write_width(input logic [15:0] w);
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.image_width <= w;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly small steps from the left neighbor, with jumps and extremes
  function automatic logic [15:0] pick_sample(input logic [15:0] prev);
    logic [15:0] delta;
    delta = 16'($urandom) >> $urandom_range(15);
    case ($urandom_range(5))
      0: return 16'($urandom);
      1, 2: return prev + delta;
      3: return prev - delta;
      4: return prev;
      default: return ($urandom_range(2) == 0) ? (prev ^ 16'h8000) :
                      ($urandom_range(1) ? 16'hFFFF : 16'h0000);
    endcase
  endfunction

  initial begin
    logic [4:0] len;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= REQ_NONE;
    req_ch.sample <= '0;
    req_ch.table_symbol <= '0;
    req_ch.table_code <= '0;
    req_ch.table_length <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.image_width <= WIDTH_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty tables: magnitude bits only, then pad them out
    send_sample(16'h8005);
    send_flush();

    // load every category; codes carry bits above their length
    for (int cat = 0; cat < NUM_CATEGORIES; cat++) begin
      if (cat == 0) len = 5'd3;
      else if (cat == 5) len = 5'd31;
      else len = 5'(((cat * 5) % 16) + 1);
      load_entry(5'(cat), (cat == 0) ? 16'hFFFF : 16'($urandom), len);
    end
    load_entry(5'd31, 16'($urandom), 5'($urandom));
    send_req(REQ_NONE, 16'($urandom), 5'($urandom), 16'($urandom), 5'($urandom));

    // zero difference leaves ones pending; the padded byte becomes 0xFF
    send_sample(16'h8000);
    send_flush();

    // extremes of the difference
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h7FFF);
    send_sample(16'hFFFE);
    send_flush();

    // random images over four idling phases
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 45; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 45; end
        default: begin send_idle_pct = 30; stall_pct = 30; end
      endcase
      for (int img = 0; img < 4; img++) begin
        write_width(WIDTH_PLAN[phase * 4 + img]);
        repeat ($urandom_range(2))
          load_entry(($urandom_range(3) == 0) ? 5'($urandom_range(31)) :
                     5'($urandom_range(16)), 16'($urandom), 5'($urandom_range(31)));
        repeat ($urandom_range(6, 14)) begin
          if ($urandom_range(15) == 0)
            send_req(REQ_NONE, 16'($urandom), 5'($urandom), 16'($urandom), 5'($urandom));
          send_sample(pick_sample(prev_px));
        end
        // leave some images open so the next width lands mid-image
        if ($urandom_range(4) != 0) send_flush();
      end
    end

    // drain, then watch a little longer for stray bytes
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
